>>> src/ptw_pkg.sv
// Shared types and constants of the proximity window tracker.
package ptw_pkg;

   localparam int POS_W       = 31;
   localparam int FEAT_W      = 4;
   localparam int CFG_COUNT_W = 5;
   localparam int CSR_IDX_W   = 2;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_FEATURE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROXIMITY_RANGE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EVAL_MODE       = 2'd3;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_PLAN   = 2'd2,
      CMD_UPDATE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [FEAT_W-1:0] feat;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic upd;
      logic drop;
   } op_type;

endpackage

>>> src/proximity_window_tracker_top.sv
// Proximity window tracker: sorted match positions and window evaluation.
//
// Requests enter on req_valid/req_stall: clear, insert a feature position,
// plan the next skip target of the head feature, or update the head position.
// Each request yields exactly one response on rsp_valid/rsp_stall carrying
// the window size, window valid flag, head feature, skip target and entry
// count. The list is a row of MAX_FEATURES cells; a request updates every
// cell in the cycle it is accepted, the window is evaluated in the next
// cycle in ST_CALC, and the response register is loaded in ST_DONE once
// rsp_stall lets a held response go. A new request is taken while idle
// or in the cycle the response register is loaded, so a request is not
// taken before the previous one has reached the response register.
// A response waiting under rsp_stall does not block the next request; a
// second finished response waits in the tracker and holds req_stall high.
// Configuration writes on csr_* take effect at once; the user must make them while idle (not enforced by the block).
// Synchronous reset empties the list, drops any pending response and loads
// the register defaults (one feature, all features needed, range 0, max mode).
module proximity_window_tracker_top
   import ptw_pkg::*;
#(
   parameter int MAX_FEATURES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_command,
   input  logic [FEAT_W-1:0]                      req_feature,
   input  logic [POS_W-1:0]                       req_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [POS_W-1:0]                       rsp_window_size,
   output logic                                   rsp_window_valid,
   output logic [FEAT_W-1:0]                      rsp_head_feature,
   output logic [POS_W-1:0]                       rsp_skip_target,
   output logic [$clog2(MAX_FEATURES+1)-1:0]      rsp_entry_count,
   input  logic                                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [POS_W-1:0]                       csr_write_data
);

   localparam int CNT_W = $clog2(MAX_FEATURES + 1);
   localparam int CMP_W = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FEATURES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FEATURES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CFG_COUNT_W-1:0] feature_count_ff, min_count_ff;
   logic [POS_W-1:0]       range_ff;
   logic                   eval_mode_ff;
   logic [CNT_W-1:0]       held_ff, held_in;

   cmd_type                cmd_ff;
   logic [POS_W-1:0]       floor_ff;
   logic [POS_W-1:0]       span_ff, tnext_ff;
   logic                   span_gt_ff, win_ok_ff;
   logic [CNT_W-1:0]       cnt_ff, count_ff;
   logic [FEAT_W-1:0]      head_feat_ff;

   logic [POS_W-1:0]       rsp_size_ff, rsp_target_ff;
   logic                   rsp_win_valid_ff;
   logic [FEAT_W-1:0]      rsp_head_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic                   accept, out_load;
   logic [CMP_W-1:0]       fc_ext, eff, need, held_ext;
   logic                   win_ok, feat_ok;
   op_type                 op;
   entry_type              new_entry;

   entry_type              cell_entry [MAX_FEATURES];
   logic [MAX_FEATURES-1:0] cell_lt;
   logic [MAX_FEATURES-1:0] cell_valid;
   logic [MAX_FEATURES:0]   win_vec;

   logic [POS_W-1:0]       head_pos, pos_need, span, tnext, size_in, target_in;
   logic                   span_gt;
   logic [CNT_W-1:0]       cnt_sel;

   // ---------------------------------------------------------------- control
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == ST_IDLE) || out_load);
   assign accept    = req_valid && !req_stall;

   assign fc_ext   = CMP_W'(feature_count_ff);
   assign eff      = (fc_ext == '0) ? CMP_W'(1) : ((fc_ext > MAX_CMP) ? MAX_CMP : fc_ext);
   assign need     = (min_count_ff != '0) ? CMP_W'(min_count_ff) : eff;
   assign held_ext = CMP_W'(held_ff);
   assign win_ok   = held_ext >= need;
   assign feat_ok  = CMP_W'(req_feature) < eff;

   always_comb begin
      op.ins  = accept && (req_command == CMD_INSERT) && (req_position != '0)
                && (held_ff < MAX_CNT) && feat_ok;
      op.upd  = accept && (req_command == CMD_UPDATE) && (held_ff != '0)
                && (req_position != '0);
      op.drop = accept && (req_command == CMD_UPDATE) && (held_ff != '0)
                && (req_position == '0);
      new_entry.pos  = req_position;
      new_entry.feat = op.upd ? cell_entry[0].feat : req_feature;
   end

   always_comb begin
      held_in = held_ff;
      if (accept && (req_command == CMD_CLEAR)) begin
         held_in = '0;
      end else if (op.ins) begin
         held_in = held_ff + CNT_W'(1);
      end else if (op.drop) begin
         held_in = held_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff          <= '0;
         feature_count_ff <= CFG_COUNT_W'(1);
         min_count_ff     <= '0;
         range_ff         <= '0;
         eval_mode_ff     <= 1'b1;
      end else begin
         held_ff <= held_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FEATURE_COUNT:   feature_count_ff <= csr_write_data[CFG_COUNT_W-1:0];
               CSR_MIN_COUNT:       min_count_ff     <= csr_write_data[CFG_COUNT_W-1:0];
               CSR_PROXIMITY_RANGE: range_ff         <= csr_write_data;
               CSR_EVAL_MODE:       eval_mode_ff     <= csr_write_data[0];
               default:             ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------ cell chain
   assign head_pos              = cell_entry[0].pos;
   assign win_vec[MAX_FEATURES] = 1'b0;

   for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_lt, right_lt;

      assign cell_valid[i] = CNT_W'(i) < held_ff;

      if (i == 0) begin : g_head
         assign left_entry = cell_entry[i];
         assign left_lt    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      if (i == MAX_FEATURES - 1) begin : g_tail
         assign right_entry = cell_entry[i];
         assign right_lt    = 1'b0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
         assign right_lt    = cell_lt[i+1];
      end

      ptw_cell #(
         .IS_HEAD (i == 0)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .new_entry   (new_entry),
         .valid       (cell_valid[i]),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .right_lt    (right_lt),
         .head_pos    (head_pos),
         .range       (range_ff),
         .entry       (cell_entry[i]),
         .lt          (cell_lt[i]),
         .in_window   (win_vec[i])
      );
   end

   // ------------------------------------------------------ window evaluation
   always_comb begin
      pos_need = '0;
      cnt_sel  = '0;
      for (int i = 0; i < MAX_FEATURES; i++) begin
         if (CMP_W'(i) == (need - CMP_W'(1))) begin
            pos_need = pos_need | cell_entry[i].pos;
         end
         if (win_vec[i] && !win_vec[i+1]) begin
            cnt_sel = cnt_sel | CNT_W'(i + 1);
         end
      end
   end

   assign span    = pos_need - head_pos;
   assign span_gt = span > range_ff;
   assign tnext   = span_gt ? (pos_need - range_ff)
                  : ((head_pos == POS_MAX) ? POS_MAX : (head_pos + POS_W'(1)));

   always_comb begin
      if (!win_ok_ff || span_gt_ff) begin
         size_in = '0;
      end else if (eval_mode_ff) begin
         size_in = POS_W'(cnt_ff);
      end else begin
         size_in = span_ff;
      end
      if ((cmd_ff == CMD_PLAN) && win_ok_ff) begin
         target_in = (tnext_ff < floor_ff) ? floor_ff : tnext_ff;
      end else begin
         target_in = '0;
      end
   end

   // ------------------------------------------------------------ sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CALC;
         ST_CALC: state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = accept ? ST_CALC : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff   <= cmd_type'(req_command);
         floor_ff <= req_position;
      end
      if (state_ff == ST_CALC) begin
         span_ff      <= span;
         span_gt_ff   <= span_gt;
         tnext_ff     <= tnext;
         win_ok_ff    <= win_ok;
         cnt_ff       <= cnt_sel;
         count_ff     <= held_ff;
         head_feat_ff <= (held_ff != '0) ? cell_entry[0].feat : '0;
      end
      if (out_load) begin
         rsp_size_ff      <= size_in;
         rsp_target_ff    <= target_in;
         rsp_win_valid_ff <= win_ok_ff;
         rsp_head_ff      <= head_feat_ff;
         rsp_count_ff     <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_size  = rsp_size_ff;
   assign rsp_window_valid = rsp_win_valid_ff;
   assign rsp_head_feature = rsp_head_ff;
   assign rsp_skip_target  = rsp_target_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // ------------------------------------------------------------ assertions
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= MAX_CNT)
      else $error("entry count above capacity");

   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CALC))
      else $error("accepted request not evaluated next cycle");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_window_valid) |-> ((rsp_window_size == '0) && (rsp_skip_target == '0)))
      else $error("window result without valid window");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_entry_count == '0)) |-> (rsp_head_feature == '0))
      else $error("head feature reported for empty list");

endmodule

>>> src/ptw_cell.sv
// One slot of the sorted position list; shifts with its neighbours.
module ptw_cell
   import ptw_pkg::*;
#(
   parameter bit IS_HEAD = 1'b0
) (
   input  logic             clock,
   input  op_type           op,
   input  entry_type        new_entry,
   input  logic             valid,
   input  entry_type        left_entry,
   input  logic             left_lt,
   input  entry_type        right_entry,
   input  logic             right_lt,
   input  logic [POS_W-1:0] head_pos,
   input  logic [POS_W-1:0] range,
   output entry_type        entry,
   output logic             lt,
   output logic             in_window
);

   entry_type entry_ff;
   entry_type entry_in;

   assign entry     = entry_ff;
   assign lt        = valid && (entry_ff.pos < new_entry.pos);
   assign in_window = valid && ((entry_ff.pos - head_pos) <= range);

   always_comb begin
      entry_in = entry_ff;
      if (op.drop) begin
         entry_in = right_entry;
      end else if (op.ins) begin
         if (!lt) begin
            if (IS_HEAD || left_lt) begin
               entry_in = new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (op.upd) begin
         if (right_lt) begin
            entry_in = right_entry;
         end else if (IS_HEAD || lt) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
